// File: design/cper_pkg.sv
// Shared types, constants and helpers for the camera pose Euler rotator.
// Used by cper_cordic and camera_pose_euler_rotator; depends on nothing.
package cper_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int FRAC_BITS    = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
   localparam int TRIG_W       = FRAC_BITS + 2;
   localparam int NUM_REGS     = 6;

   // 360 degrees in Q16.16
   localparam logic [24:0] ANGLE_MOD = 25'd23592960;

   // CORDIC gain compensation, Q30
   localparam longint CORDIC_K = 64'sd652032874
      + ((64'sd434688583 + (64'sd1 <<< (2 * CORDIC_STEPS - 1))) >>> (2 * CORDIC_STEPS));

   typedef enum logic [1:0] {
      KIND_ROTATE    = 2'd0,
      KIND_TRANSLATE = 2'd1,
      KIND_MOVE      = 2'd2,
      KIND_SET_POS   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_LOOK_X = 3'd0,
      CSR_LOOK_Y = 3'd1,
      CSR_LOOK_Z = 3'd2,
      CSR_UP_X   = 3'd3,
      CSR_UP_Y   = 3'd4,
      CSR_UP_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] look_x;
      logic signed [31:0] look_y;
      logic signed [31:0] look_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
      logic [24:0]        pitch_deg;
      logic [24:0]        yaw_deg;
      logic [24:0]        roll_deg;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [24:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } cordic_rsp_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [31:0] atan_deg(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'd754974720;
         5'd1:  r = 32'd445687602;
         5'd2:  r = 32'd235489088;
         5'd3:  r = 32'd119537938;
         5'd4:  r = 32'd60000934;
         5'd5:  r = 32'd30029717;
         5'd6:  r = 32'd15018523;
         5'd7:  r = 32'd7509720;
         5'd8:  r = 32'd3754917;
         5'd9:  r = 32'd1877466;
         5'd10: r = 32'd938734;
         5'd11: r = 32'd469367;
         5'd12: r = 32'd234684;
         5'd13: r = 32'd117342;
         5'd14: r = 32'd58671;
         5'd15: r = 32'd29335;
         5'd16: r = 32'd14668;
         5'd17: r = 32'd7334;
         5'd18: r = 32'd3667;
         5'd19: r = 32'd1833;
         5'd20: r = 32'd917;
         5'd21: r = 32'd458;
         5'd22: r = 32'd229;
         5'd23: r = 32'd115;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: design/camera_pose_euler_rotator.sv
// Camera pose keeper: top level with the sequencer, shared multiplier and pose state.
// Depends on cper_pkg and cper_cordic.
//
// One item is taken at a time; req_ready is high only while the sequencer is
// idle, and a finished result waits in the output register so that the next
// item can be taken before it is collected. Each angle wrap in rotate is a
// nine-step compare-subtract, and each of the three axis turns in rotate and
// set-position runs the CORDIC and then the one shared multiplier for each of
// the look and up pairs. Start vectors are taken from the csr registers only
// when a rotate or set-position runs.
module camera_pose_euler_rotator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cper_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cper_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_WRAP   = 10'b0000000010,
      S_LOAD   = 10'b0000000100,
      S_TRIG   = 10'b0000001000,
      S_WAIT   = 10'b0000010000,
      S_TURN   = 10'b0000100000,
      S_ADDPOS = 10'b0001000000,
      S_TRANS  = 10'b0010000000,
      S_MOVE   = 10'b0100000000,
      S_FINISH = 10'b1000000000
   } state_type;

   localparam logic signed [33:0] MOD128 = 34'sd3019898880;
   localparam logic signed [65:0] HALF_F = 66'sd1 <<< (cper_pkg::FRAC_BITS - 1);

   state_type state_ff, state_in;
   cper_pkg::kind_type kind_ff, kind_in;
   logic signed [31:0] val_ff [3];
   logic signed [31:0] val_in [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vec_ff [6];   // look 0..2, up 3..5
   logic signed [31:0] vec_in [6];
   logic signed [31:0] regs_ff [6];
   logic [24:0] ang_ff [3];          // 0 roll, 1 pitch, 2 yaw
   logic [24:0] ang_in [3];
   logic [1:0] j_ff, j_in;
   logic p_ff, p_in;
   logic [3:0] wk_ff, wk_in;
   logic [2:0] ms_ff, ms_in;
   logic signed [33:0] w_ff, w_in;
   logic signed [cper_pkg::TRIG_W-1:0] c_ff, c_in, s_ff, s_in;
   logic signed [65:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic signed [32:0] op_a;
   logic signed [31:0] op_b;
   logic signed [64:0] prod_ff;
   logic rsp_valid_ff, rsp_valid_in;
   cper_pkg::rsp_type rsp_ff, rsp_in;
   cper_pkg::cordic_req_type cor_req;
   cper_pkg::cordic_rsp_type cor_rsp;

   cper_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_req),
      .res   (cor_rsp)
   );

   // pair indices for the current axis and vector
   logic [2:0] ia, ib, isel;
   always_comb begin
      logic [2:0] base;
      base = p_ff ? 3'd3 : 3'd0;
      unique case (j_ff)
         2'd0:    begin ia = base + 3'd1; ib = base + 3'd2; end
         2'd1:    begin ia = base + 3'd2; ib = base;        end
         default: begin ia = base;        ib = base + 3'd1; end
      endcase
      isel = ms_ff[0] ? ib : ia;
   end

   always_comb begin
      logic signed [33:0] sum, mk;
      logic signed [65:0] rnd, mag, dl;
      logic [24:0] angle_sel;
      state_in = state_ff; kind_in = kind_ff;
      val_in = val_ff; pos_in = pos_ff; vec_in = vec_ff; ang_in = ang_ff;
      j_in = j_ff; p_in = p_ff; wk_in = wk_ff; ms_in = ms_ff; w_in = w_ff;
      c_in = c_ff; s_in = s_ff; acc_a_in = acc_a_ff; acc_b_in = acc_b_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      op_a = '0; op_b = '0;
      sum = $signed({9'b0, ang_ff[j_ff]}) + 34'(val_ff[j_ff]);
      mk = $signed({9'b0, cper_pkg::ANGLE_MOD}) <<< wk_ff[2:0];
      rnd = '0; mag = '0; dl = '0;
      unique case (j_ff)
         2'd0:    angle_sel = ang_ff[1];
         2'd1:    angle_sel = ang_ff[2];
         default: angle_sel = ang_ff[0];
      endcase
      cor_req.start = 1'b0;
      cor_req.angle = angle_sel;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind;
               val_in[0] = req_data.value_a;
               val_in[1] = req_data.value_b;
               val_in[2] = req_data.value_c;
               j_in = 2'd0;
               ms_in = 3'd0;
               wk_in = 4'd8;
               unique case (req_data.kind)
                  cper_pkg::KIND_ROTATE:    state_in = S_WRAP;
                  cper_pkg::KIND_TRANSLATE: state_in = S_TRANS;
                  cper_pkg::KIND_MOVE:      state_in = S_MOVE;
                  default: begin
                     pos_in[0] = req_data.value_a;
                     pos_in[1] = req_data.value_b;
                     pos_in[2] = req_data.value_c;
                     state_in = S_LOAD;
                  end
               endcase
            end
         end
         S_WRAP: begin
            // bring old + delta into range, then strip multiples of 360 from 128x down
            if (wk_ff == 4'd8) begin
               w_in = (sum < 0) ? sum + MOD128 : sum;
               wk_in = 4'd7;
            end else begin
               w_in = (w_ff >= mk) ? w_ff - mk : w_ff;
               if (wk_ff == 4'd0) begin
                  ang_in[j_ff] = w_in[24:0];
                  wk_in = 4'd8;
                  if (j_ff == 2'd2) begin
                     state_in = S_LOAD;
                  end else begin
                     j_in = j_ff + 2'd1;
                  end
               end else begin
                  wk_in = wk_ff - 4'd1;
               end
            end
         end
         S_LOAD: begin
            vec_in = regs_ff;
            j_in = 2'd0;
            state_in = S_TRIG;
         end
         S_TRIG: begin
            cor_req.start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cor_rsp.done) begin
               c_in = cor_rsp.cos_val;
               s_in = cor_rsp.sin_val;
               p_in = 1'b0;
               ms_in = 3'd0;
               state_in = S_TURN;
            end
         end
         S_TURN: begin
            // a' = c*a - s*b, b' = s*a + c*b on the shared multiplier
            op_a = 33'(vec_ff[isel]);
            op_b = (ms_ff == 3'd0 || ms_ff == 3'd3) ? 32'(c_ff) : 32'(s_ff);
            ms_in = ms_ff + 3'd1;
            unique case (ms_ff)
               3'd1: acc_a_in = 66'(prod_ff);
               3'd2: acc_a_in = acc_a_ff - 66'(prod_ff);
               3'd3: acc_b_in = 66'(prod_ff);
               3'd4: acc_b_in = acc_b_ff + 66'(prod_ff);
               3'd5: begin
                  rnd = (acc_a_ff + HALF_F) >>> cper_pkg::FRAC_BITS;
                  vec_in[ia] = cper_pkg::sat32(rnd);
               end
               3'd6: begin
                  rnd = (acc_b_ff + HALF_F) >>> cper_pkg::FRAC_BITS;
                  vec_in[ib] = cper_pkg::sat32(rnd);
                  ms_in = 3'd0;
                  if (!p_ff) begin
                     p_in = 1'b1;
                  end else if (j_ff == 2'd2) begin
                     state_in = S_ADDPOS;
                  end else begin
                     j_in = j_ff + 2'd1;
                     state_in = S_TRIG;
                  end
               end
               default: ;
            endcase
         end
         S_ADDPOS: begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = cper_pkg::sat32(66'(vec_ff[i]) + 66'(pos_ff[i]));
            end
            state_in = S_FINISH;
         end
         S_TRANS: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i] = cper_pkg::sat32(66'(pos_ff[i]) + 66'(val_ff[i]));
               vec_in[i] = cper_pkg::sat32(66'(vec_ff[i]) + 66'(val_ff[i]));
            end
            state_in = S_FINISH;
         end
         S_MOVE: begin
            op_a = 33'(vec_ff[{1'b0, j_ff}]) - 33'(pos_ff[j_ff]);
            op_b = val_ff[0];
            if (ms_ff == 3'd0) begin
               ms_in = 3'd1;
            end else begin
               // round half away from zero
               mag = (prod_ff < 0) ? -66'(prod_ff) : 66'(prod_ff);
               rnd = (mag + 66'sd32768) >>> 16;
               dl = (prod_ff < 0) ? -rnd : rnd;
               pos_in[j_ff] = cper_pkg::sat32(66'(pos_ff[j_ff]) + dl);
               vec_in[{1'b0, j_ff}] = cper_pkg::sat32(66'(vec_ff[{1'b0, j_ff}]) + dl);
               ms_in = 3'd0;
               if (j_ff == 2'd2) begin
                  state_in = S_FINISH;
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pos_x = pos_ff[0];
               rsp_in.pos_y = pos_ff[1];
               rsp_in.pos_z = pos_ff[2];
               rsp_in.look_x = vec_ff[0];
               rsp_in.look_y = vec_ff[1];
               rsp_in.look_z = vec_ff[2];
               rsp_in.up_x = vec_ff[3];
               rsp_in.up_y = vec_ff[4];
               rsp_in.up_z = vec_ff[5];
               rsp_in.pitch_deg = ang_ff[1];
               rsp_in.yaw_deg = ang_ff[2];
               rsp_in.roll_deg = ang_ff[0];
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff <= cper_pkg::KIND_ROTATE;
         j_ff <= 2'd0;
         p_ff <= 1'b0;
         wk_ff <= 4'd8;
         ms_ff <= 3'd0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            ang_ff[i] <= '0;
         end
         vec_ff[0] <= '0; vec_ff[1] <= '0; vec_ff[2] <= 32'sd65536;
         vec_ff[3] <= '0; vec_ff[4] <= 32'sd65536; vec_ff[5] <= '0;
         regs_ff[cper_pkg::CSR_LOOK_X] <= '0;
         regs_ff[cper_pkg::CSR_LOOK_Y] <= '0;
         regs_ff[cper_pkg::CSR_LOOK_Z] <= 32'sd65536;
         regs_ff[cper_pkg::CSR_UP_X] <= '0;
         regs_ff[cper_pkg::CSR_UP_Y] <= 32'sd65536;
         regs_ff[cper_pkg::CSR_UP_Z] <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff <= kind_in;
         j_ff <= j_in;
         p_ff <= p_in;
         wk_ff <= wk_in;
         ms_ff <= ms_in;
         pos_ff <= pos_in;
         ang_ff <= ang_in;
         vec_ff <= vec_in;
         // drop writes beyond the register list
         if (csr_we && csr_index < 3'(cper_pkg::NUM_REGS)) begin
            regs_ff[csr_index] <= csr_wdata;
         end
      end
      val_ff <= val_in;
      w_ff <= w_in;
      c_ff <= c_in;
      s_ff <= s_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      prod_ff <= op_a * op_b;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/cper_cordic.sv
// Iterative CORDIC giving cosine and sine of an angle in degrees (Q16.16).
// Depends on cper_pkg; one micro-rotation per cycle.
module cper_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  cper_pkg::cordic_req_type cmd,
   output cper_pkg::cordic_rsp_type res
);

   localparam logic signed [33:0] D90  = 34'sd1509949440;
   localparam logic signed [33:0] D180 = 34'sd3019898880;
   localparam logic signed [33:0] D360 = 34'sd6039797760;
   localparam logic signed [33:0] TRIG_RND = 34'sd1 <<< (29 - cper_pkg::FRAC_BITS);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [cper_pkg::STEP_W-1:0] i_ff, i_in;
   logic signed [cper_pkg::TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;

   always_comb begin
      logic signed [33:0] z0, zw, xs, ys, at, xr, yr, cr, sr;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; neg_in = neg_ff;
      i_in = i_ff; busy_in = busy_ff; done_in = 1'b0;
      cos_in = cos_ff; sin_in = sin_ff;
      z0 = $signed({1'b0, cmd.angle, 8'b0});
      zw = (z0 >= D180) ? z0 - D360 : z0;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = $signed({2'b00, cper_pkg::atan_deg(5'(i_ff))});
      xr = neg_ff ? -x_ff : x_ff;
      yr = neg_ff ? -y_ff : y_ff;
      cr = (xr + TRIG_RND) >>> (30 - cper_pkg::FRAC_BITS);
      sr = (yr + TRIG_RND) >>> (30 - cper_pkg::FRAC_BITS);
      if (cmd.start) begin
         x_in = 34'(cper_pkg::CORDIC_K);
         y_in = '0;
         i_in = '0;
         busy_in = 1'b1;
         // fold into [-90, 90]; negate at the end when folded by 180
         if (zw > D90) begin
            z_in = zw - D180; neg_in = 1'b1;
         end else if (zw < -D90) begin
            z_in = zw + D180; neg_in = 1'b1;
         end else begin
            z_in = zw; neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (i_ff == cper_pkg::STEP_W'(cper_pkg::CORDIC_STEPS)) begin
            cos_in = cr[cper_pkg::TRIG_W-1:0];
            sin_in = sr[cper_pkg::TRIG_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end
            i_in = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; neg_ff <= neg_in;
      i_ff <= i_in; cos_ff <= cos_in; sin_ff <= sin_in;
   end

   assign res.done    = done_ff;
   assign res.cos_val = cos_ff;
   assign res.sin_val = sin_ff;

endmodule
